### rtl/tsfr_pkg.sv
package tsfr_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IGNORE_TIME     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_OFF     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_ON      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_RECOVER    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RECOVER_ATTEMPT = 3'd4;

    // Register reset values
    localparam logic [7:0]  IGNORE_TIME_RST      = 8'd8;
    localparam logic [7:0]  RECOVER_OFF_RST      = 8'd4;
    localparam logic [7:0]  RECOVER_ON_RST       = 8'd1;
    localparam logic [15:0] SLOW_RECOVER_RST     = 16'd1000;
    localparam logic [3:0]  RECOVER_ATTEMPTS_RST = 4'd3;

    // Phase codes as reported on the result
    localparam logic [2:0] PHASE_IDLE        = 3'd0;
    localparam logic [2:0] PHASE_IGNORE      = 3'd1;
    localparam logic [2:0] PHASE_RECOVER_OFF = 3'd2;
    localparam logic [2:0] PHASE_RECOVER_ON  = 3'd3;
    localparam logic [2:0] PHASE_SHORTED     = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE        = 5'b00001,
        ST_IGNORE      = 5'b00010,
        ST_RECOVER_OFF = 5'b00100,
        ST_RECOVER_ON  = 5'b01000,
        ST_SHORTED     = 5'b10000
    } state_t;

    typedef struct packed {
        logic [7:0]  ignore_time_ms;
        logic [7:0]  recover_off_ms;
        logic [7:0]  recover_on_ms;
        logic [15:0] slow_recover_ms;
        logic [3:0]  recover_attempts;
    } cfg_t;

    typedef struct packed {
        logic       track_enable;
        logic       short_report;
        logic [2:0] phase;
    } result_t;

    // Map the one-hot state onto the reported phase code
    function automatic logic [2:0] state_to_phase(input state_t st);
        logic [2:0] code;
        case (st)
            ST_IGNORE:      code = PHASE_IGNORE;
            ST_RECOVER_OFF: code = PHASE_RECOVER_OFF;
            ST_RECOVER_ON:  code = PHASE_RECOVER_ON;
            ST_SHORTED:     code = PHASE_SHORTED;
            default:        code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

### rtl/track_short_fast_recovery.sv
// Short-circuit guard with hiccup recovery for one track output. Each input
// transfer is one millisecond tick carrying the sampled short sense and a
// restore request; each tick yields exactly one result (track enable, short
// report, phase). A tick is taken in every cycle in which the buffer has
// space: the phase logic sits between the state registers and a result
// register, and a two-entry output buffer lets a new tick be accepted while
// a result still waits to be taken. Timing registers are written on the cfg
// channel (always ready); the user must write them only while no tick is in
// flight (not enforced); indexes beyond the last register are ignored.
module track_short_fast_recovery #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             short_sensed,
    input  logic                             restore,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             track_enable,
    output logic                             short_report,
    output logic [2:0]                       phase,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    tsfr_pkg::cfg_t    cfg_reg;
    tsfr_pkg::result_t step_result;
    tsfr_pkg::result_t out_data;
    logic              step;
    logic              space;

    assign cfg_ready = 1'b1;
    assign in_ready  = space;
    assign step      = in_valid && space;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ignore_time_ms   <= tsfr_pkg::IGNORE_TIME_RST;
            cfg_reg.recover_off_ms   <= tsfr_pkg::RECOVER_OFF_RST;
            cfg_reg.recover_on_ms    <= tsfr_pkg::RECOVER_ON_RST;
            cfg_reg.slow_recover_ms  <= tsfr_pkg::SLOW_RECOVER_RST;
            cfg_reg.recover_attempts <= tsfr_pkg::RECOVER_ATTEMPTS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tsfr_pkg::CFG_IGNORE_TIME:     cfg_reg.ignore_time_ms   <= cfg_data[7:0];
                tsfr_pkg::CFG_RECOVER_OFF:     cfg_reg.recover_off_ms   <= cfg_data[7:0];
                tsfr_pkg::CFG_RECOVER_ON:      cfg_reg.recover_on_ms    <= cfg_data[7:0];
                tsfr_pkg::CFG_SLOW_RECOVER:    cfg_reg.slow_recover_ms  <= cfg_data[15:0];
                tsfr_pkg::CFG_RECOVER_ATTEMPT: cfg_reg.recover_attempts <= cfg_data[3:0];
                default:                       cfg_reg <= cfg_reg;
            endcase
        end
    end

    tsfr_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .short_sensed (short_sensed),
        .restore      (restore),
        .cfg          (cfg_reg),
        .result       (step_result)
    );

    tsfr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_result),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign track_enable = out_data.track_enable;
    assign short_report = out_data.short_report;
    assign phase        = out_data.phase;

endmodule

### rtl/tsfr_core.sv
module tsfr_core #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              short_sensed,
    input  logic              restore,
    input  tsfr_pkg::cfg_t    cfg,
    output tsfr_pkg::result_t result
);

    localparam int unsigned CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    tsfr_pkg::state_t       state_reg;
    tsfr_pkg::state_t       state_next;
    logic [TIMER_WIDTH-1:0] elapsed_reg;
    logic [TIMER_WIDTH-1:0] elapsed_next;
    logic [TIMER_WIDTH-1:0] elapsed_inc;
    logic [3:0]             attempts_reg;
    logic [3:0]             attempts_next;
    logic [3:0]             attempts_dec;
    logic                   enable_reg;
    logic                   enable_next;
    logic                   report;

    // Saturating tick count and the phase-end compares
    logic [TIMER_WIDTH-1:0] ignore_ext;
    logic [TIMER_WIDTH-1:0] off_ext;
    logic [TIMER_WIDTH-1:0] on_ext;
    logic [CMP_W-1:0]       elapsed_wide;
    logic [CMP_W-1:0]       slow_wide;

    assign elapsed_inc  = (elapsed_reg == {TIMER_WIDTH{1'b1}}) ? elapsed_reg
                                                               : elapsed_reg + 1'b1;
    assign ignore_ext   = {{(TIMER_WIDTH-8){1'b0}}, cfg.ignore_time_ms};
    assign off_ext      = {{(TIMER_WIDTH-8){1'b0}}, cfg.recover_off_ms};
    assign on_ext       = {{(TIMER_WIDTH-8){1'b0}}, cfg.recover_on_ms};
    assign elapsed_wide = CMP_W'(elapsed_inc);
    assign slow_wide    = CMP_W'(cfg.slow_recover_ms);
    assign attempts_dec = attempts_reg - 4'd1;

    // Work out the state after this tick
    always_comb
    begin
        state_next    = state_reg;
        elapsed_next  = elapsed_inc;
        attempts_next = attempts_reg;
        enable_next   = enable_reg | restore;
        report        = 1'b0;
        case (state_reg)
            tsfr_pkg::ST_IGNORE:
            begin
                if (!short_sensed)
                begin
                    state_next  = tsfr_pkg::ST_IDLE;
                    enable_next = 1'b1;
                end
                else if (elapsed_inc > ignore_ext)
                begin
                    state_next    = tsfr_pkg::ST_RECOVER_OFF;
                    attempts_next = cfg.recover_attempts;
                    enable_next   = 1'b0;
                    elapsed_next  = '0;
                end
            end
            tsfr_pkg::ST_RECOVER_OFF:
            begin
                if (elapsed_inc > off_ext)
                begin
                    state_next   = tsfr_pkg::ST_RECOVER_ON;
                    enable_next  = 1'b1;
                    elapsed_next = '0;
                end
            end
            tsfr_pkg::ST_RECOVER_ON:
            begin
                if (elapsed_inc > on_ext)
                begin
                    if (short_sensed)
                    begin
                        elapsed_next  = '0;
                        enable_next   = 1'b0;
                        attempts_next = attempts_dec;
                        if (attempts_dec == 4'd0)
                        begin
                            state_next = tsfr_pkg::ST_SHORTED;
                            report     = 1'b1;
                        end
                        else
                        begin
                            state_next = tsfr_pkg::ST_RECOVER_OFF;
                        end
                    end
                    else
                    begin
                        state_next  = tsfr_pkg::ST_IDLE;
                        enable_next = 1'b1;
                    end
                end
            end
            tsfr_pkg::ST_SHORTED:
            begin
                if (short_sensed)
                begin
                    elapsed_next = '0;
                    report       = 1'b1;
                end
                else if (elapsed_wide > slow_wide)
                begin
                    state_next = tsfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsfr_pkg::ST_IDLE;
                if (short_sensed)
                begin
                    state_next   = tsfr_pkg::ST_IGNORE;
                    elapsed_next = '0;
                end
            end
        endcase
    end

    // Advance the state on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tsfr_pkg::ST_IDLE;
            elapsed_reg  <= '0;
            attempts_reg <= '0;
            enable_reg   <= 1'b1;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            attempts_reg <= attempts_next;
            enable_reg   <= enable_next;
        end
    end

    assign result.track_enable = enable_next;
    assign result.short_report = report;
    assign result.phase        = tsfr_pkg::state_to_phase(state_next);

endmodule

### rtl/tsfr_out_buf.sv
module tsfr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsfr_pkg::result_t push_data,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output tsfr_pkg::result_t out_data
);

    logic              main_valid_reg;
    tsfr_pkg::result_t main_data_reg;
    logic              skid_valid_reg;
    tsfr_pkg::result_t skid_data_reg;
    logic              main_free;

    // The skid entry catches one result while the output is stalled
    assign main_free = !main_valid_reg || out_ready;
    assign space     = !skid_valid_reg;

    // Hold control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Move payload: skid drains into the output register first
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule
